>>> rtl/frwm_pkg.sv
// Constants and codes shared by the frame rate window monitor.
package frwm_pkg;

	localparam int unsigned WINDOW = 64;
	localparam int unsigned PTR_W  = $clog2(WINDOW);
	localparam int unsigned FILL_W = $clog2(WINDOW + 1);
	localparam int unsigned DEN_W  = 32 + $clog2(WINDOW);
	localparam int unsigned CMP_W  = (DEN_W + 24 > 64) ? DEN_W + 24 : 64;

	localparam logic [31:0] RATE_SAT  = 32'hFFFF_FFFF;
	localparam logic [31:0] TPS_RESET = 32'd1000000;

	localparam int unsigned JOB_W = 3;
	localparam logic [JOB_W-1:0] JOB_CUR  = 3'd0;
	localparam logic [JOB_W-1:0] JOB_MEAN = 3'd1;
	localparam logic [JOB_W-1:0] JOB_MIN  = 3'd2;
	localparam logic [JOB_W-1:0] JOB_MAX  = 3'd3;
	localparam logic [JOB_W-1:0] JOB_ALL  = 3'd4;
	localparam int unsigned JOB_CNT = 5;

endpackage

>>> rtl/frwm_if.sv
// Word channels of the frame rate window monitor: timestamps in, statistics out.
interface frwm_frame_if;
	logic        valid;
	logic        ready;
	logic [31:0] timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink (input valid, input timestamp, output ready);
endinterface

interface frwm_stats_if;
	logic        valid;
	logic        ready;
	logic        stats_valid;
	logic [31:0] delta_ticks;
	logic [31:0] current_rate;
	logic [31:0] mean_rate;
	logic [31:0] min_rate;
	logic [31:0] max_rate;
	logic [31:0] overall_rate;
	logic [31:0] frames_seen;

	modport source (output valid, output stats_valid, output delta_ticks,
		output current_rate, output mean_rate, output min_rate, output max_rate,
		output overall_rate, output frames_seen, input ready);
	modport sink (input valid, input stats_valid, input delta_ticks,
		input current_rate, input mean_rate, input min_rate, input max_rate,
		input overall_rate, input frames_seen, output ready);
endinterface

>>> rtl/frame_rate_window_monitor_unit.sv
// Frame rate window monitor: delta ring in RAM, serial scan, shared serial divider.
//
//  channel    dir  width  contents
//  frame      in   32     timestamp word
//  stats      out  225    stats_valid, delta and rates, frames_seen word
//  tps_we/wd  in   32     tick rate register write
//
// One word at a time. The first word after reset goes straight to the finish state.
// Later words pass through the ring write, a scan of the filled ring entries, 5 serial
// divisions and the finish state, which loads the output register.
// frame.ready is high only in idle; a result waiting on stats does not block it.
// Reset clears all control state; ring entries are read only once written.
module frame_rate_window_monitor_unit
	import frwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tps_we,
	input  logic [31:0]         tps_wdata,
	frwm_frame_if.sink          frame,
	frwm_stats_if.source        stats
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WRITE  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_CHK    = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0]        state_q;
	logic [31:0]       tps_q;
	logic              started_q;
	logic              first_q;
	logic [31:0]       start_q;
	logic [31:0]       prev_q;
	logic [31:0]       frame_total_q;
	logic [31:0]       delta_q;
	logic [31:0]       odiv_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] idx_q;
	logic              rd_vld_s1;
	logic [31:0]       rd_data_s1;
	logic [DEN_W-1:0]  sum_q;
	logic [31:0]       dmin_q;
	logic [31:0]       dmax_q;
	logic [JOB_W-1:0]  job_q;
	logic [63:0]       num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [31:0]       dsh_q;
	logic [31:0]       quo_q;
	logic [4:0]        cnt_q;
	logic [31:0]       res_q [JOB_CNT];
	logic              out_valid_q;

	logic [31:0]       ring_mem [WINDOW];

	logic              accept;
	logic              mem_we;
	logic [PTR_W-1:0]  rd_addr;
	logic [31:0]       mul_a;
	logic [63:0]       prod;
	logic [DEN_W-1:0]  den_sel;
	logic [CMP_W-1:0]  num_ext;
	logic [CMP_W-1:0]  den_ext;
	logic              ovf;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic              out_free;

	assign frame.ready = (state_q == ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign mem_we      = (state_q == ST_WRITE);
	assign rd_addr     = idx_q[PTR_W-1:0];
	assign out_free    = !out_valid_q || stats.ready;

	always_comb begin
		case (job_q)
			JOB_MEAN: begin
				mul_a   = 32'(fill_q);
				den_sel = sum_q;
			end
			JOB_MIN: begin
				mul_a   = 32'd1;
				den_sel = DEN_W'(dmax_q);
			end
			JOB_MAX: begin
				mul_a   = 32'd1;
				den_sel = DEN_W'(dmin_q);
			end
			JOB_ALL: begin
				mul_a   = frame_total_q;
				den_sel = DEN_W'(odiv_q);
			end
			default: begin
				mul_a   = 32'd1;
				den_sel = DEN_W'(delta_q);
			end
		endcase
	end

	assign prod    = mul_a * tps_q;
	// quotient of num*256/den reaches 2^32 exactly when num >= den * 2^24
	assign num_ext = CMP_W'(num_q);
	assign den_ext = CMP_W'(den_q) << 24;
	assign ovf     = (den_q == '0) || (num_ext >= den_ext);
	assign trial   = {rem_q, dsh_q[31]};
	assign ge      = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[ptr_q] <= delta_q;
		end
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (tps_we) begin
			tps_q <= tps_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			started_q     <= 1'b0;
			first_q       <= 1'b0;
			start_q       <= '0;
			prev_q        <= '0;
			frame_total_q <= '0;
			ptr_q         <= '0;
			fill_q        <= '0;
			idx_q         <= '0;
			rd_vld_s1     <= 1'b0;
			job_q         <= JOB_CUR;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (stats.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!started_q) begin
							started_q <= 1'b1;
							first_q   <= 1'b1;
							start_q   <= frame.timestamp;
							prev_q    <= frame.timestamp;
							state_q   <= ST_FINISH;
						end else begin
							first_q <= 1'b0;
							prev_q  <= frame.timestamp;
							if (frame_total_q != 32'hFFFF_FFFF) begin
								frame_total_q <= frame_total_q + 32'd1;
							end
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
					if (fill_q != FILL_W'(WINDOW)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					idx_q     <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q != fill_q) begin
						idx_q     <= idx_q + FILL_W'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						if (!rd_vld_s1) begin
							job_q   <= JOB_CUR;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cnt_q <= '0;
					if (ovf) begin
						if (job_q == JOB_ALL) begin
							state_q <= ST_FINISH;
						end else begin
							job_q   <= job_q + JOB_W'(1);
							state_q <= ST_MUL;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						if (job_q == JOB_ALL) begin
							state_q <= ST_FINISH;
						end else begin
							job_q   <= job_q + JOB_W'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= frame.timestamp - prev_q;
			odiv_q  <= frame.timestamp - start_q;
		end
		if (state_q == ST_WRITE) begin
			sum_q  <= '0;
			dmin_q <= 32'hFFFF_FFFF;
			dmax_q <= '0;
		end else if (state_q == ST_SCAN && rd_vld_s1) begin
			sum_q <= sum_q + DEN_W'(rd_data_s1);
			if (rd_data_s1 < dmin_q) begin
				dmin_q <= rd_data_s1;
			end
			if (rd_data_s1 > dmax_q) begin
				dmax_q <= rd_data_s1;
			end
		end
		if (state_q == ST_MUL) begin
			num_q <= prod;
			den_q <= den_sel;
		end
		if (state_q == ST_CHK) begin
			rem_q <= DEN_W'(num_ext >> 24);
			dsh_q <= {num_q[23:0], 8'h00};
			if (ovf) begin
				res_q[job_q] <= RATE_SAT;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			dsh_q <= {dsh_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
			if (cnt_q == 5'd31) begin
				res_q[job_q] <= {quo_q[30:0], ge};
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			stats.stats_valid <= !first_q;
			if (first_q) begin
				stats.delta_ticks  <= '0;
				stats.current_rate <= '0;
				stats.mean_rate    <= '0;
				stats.min_rate     <= '0;
				stats.max_rate     <= '0;
				stats.overall_rate <= '0;
				stats.frames_seen  <= '0;
			end else begin
				stats.delta_ticks  <= delta_q;
				stats.current_rate <= res_q[JOB_CUR];
				stats.mean_rate    <= res_q[JOB_MEAN];
				stats.min_rate     <= res_q[JOB_MIN];
				stats.max_rate     <= res_q[JOB_MAX];
				stats.overall_rate <= res_q[JOB_ALL];
				stats.frames_seen  <= frame_total_q;
			end
		end
	end

	assign stats.valid = out_valid_q;

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("ring fill above window");

	ap_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_q != $past(state_q) && $past(state_q) == ST_WRITE)
		|-> !rd_vld_s1)
		else $error("stale read pending at scan start");

	ap_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= fill_q))
		else $error("scan index past fill");

	ap_div_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_CHK || state_q == ST_MUL)
		|-> (job_q <= JOB_ALL))
		else $error("divider job out of range");

	ap_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !stats.stats_valid) |-> (stats.frames_seen == '0))
		else $error("first result carries a frame count");

endmodule
